// ===== rtl/core/sjkw_pkg.sv =====
// sjkw_pkg: shared types, codes and kana tables for the Shift-JIS kana
// width converter. No dependencies; imported by the top level, sjkw_step and the bench.
package sjkw_pkg;

  // Conversion modes
  localparam logic [1:0] MODE_HALF     = 2'd0;  // full-width katakana to half
  localparam logic [1:0] MODE_KATA     = 2'd1;  // half-width to full katakana
  localparam logic [1:0] MODE_HIRA     = 2'd2;  // half-width to full hiragana
  localparam logic [1:0] MODE_HIRA_ALT = 2'd3;  // treated as hiragana

  // What the pending register holds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LEAD = 2'd1;
  localparam logic [1:0] KIND_KANA = 2'd2;

  localparam logic [15:0] SJIS_IDEO_SPACE = 16'h8140;
  localparam logic [7:0]  ASCII_SPACE     = 8'h20;
  localparam logic [7:0]  KANA_LO         = 8'hA0;
  localparam logic [7:0]  KANA_HI         = 8'hDF;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PAIR_N   = 26;
  localparam int SINGLE_N = 64;

  localparam logic [7:0] PAIR_BASE [PAIR_N] = '{
    8'hB3, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
    8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hCA, 8'hCB, 8'hCC, 8'hCD,
    8'hCE, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE
  };
  localparam logic [7:0] PAIR_MARK [PAIR_N] = '{
    8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE,
    8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE, 8'hDE,
    8'hDE, 8'hDF, 8'hDF, 8'hDF, 8'hDF, 8'hDF
  };
  localparam logic [15:0] PAIR_HIRA [PAIR_N] = '{
    16'h8394, 16'h82AA, 16'h82AC, 16'h82AE, 16'h82B0, 16'h82B2, 16'h82B4,
    16'h82B6, 16'h82B8, 16'h82BA, 16'h82BC, 16'h82BE, 16'h82C0, 16'h82C3,
    16'h82C5, 16'h82C7, 16'h82CE, 16'h82D1, 16'h82D4, 16'h82D7, 16'h82DA,
    16'h82CF, 16'h82D2, 16'h82D5, 16'h82D8, 16'h82DB
  };
  localparam logic [15:0] PAIR_KATA [PAIR_N] = '{
    16'h8394, 16'h834B, 16'h834D, 16'h834F, 16'h8351, 16'h8353, 16'h8355,
    16'h8357, 16'h8359, 16'h835B, 16'h835D, 16'h835F, 16'h8361, 16'h8364,
    16'h8366, 16'h8368, 16'h836F, 16'h8372, 16'h8375, 16'h8378, 16'h837B,
    16'h8370, 16'h8373, 16'h8376, 16'h8379, 16'h837C
  };

  // Indexed by half-width code minus 0xA0
  localparam logic [15:0] HIRA_TAB [SINGLE_N] = '{
    16'h8140, 16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h82F0, 16'h829F,
    16'h82A1, 16'h82A3, 16'h82A5, 16'h82A7, 16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1,
    16'h815B, 16'h82A0, 16'h82A2, 16'h82A4, 16'h82A6, 16'h82A8, 16'h82A9, 16'h82AB,
    16'h82AD, 16'h82AF, 16'h82B1, 16'h82B3, 16'h82B5, 16'h82B7, 16'h82B9, 16'h82BB,
    16'h82BD, 16'h82BF, 16'h82C2, 16'h82C4, 16'h82C6, 16'h82C8, 16'h82C9, 16'h82CA,
    16'h82CB, 16'h82CC, 16'h82CD, 16'h82D0, 16'h82D3, 16'h82D6, 16'h82D9, 16'h82DC,
    16'h82DD, 16'h82DE, 16'h82DF, 16'h82E0, 16'h82E2, 16'h82E4, 16'h82E6, 16'h82E7,
    16'h82E8, 16'h82E9, 16'h82EA, 16'h82EB, 16'h82ED, 16'h82F1, 16'h814A, 16'h814B
  };
  localparam logic [15:0] KATA_TAB [SINGLE_N] = '{
    16'h8140, 16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340,
    16'h8342, 16'h8344, 16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362,
    16'h815B, 16'h8341, 16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834A, 16'h834C,
    16'h834E, 16'h8350, 16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835A, 16'h835C,
    16'h835E, 16'h8360, 16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836A, 16'h836B,
    16'h836C, 16'h836D, 16'h836E, 16'h8371, 16'h8374, 16'h8377, 16'h837A, 16'h837D,
    16'h837E, 16'h8380, 16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389,
    16'h838A, 16'h838B, 16'h838C, 16'h838D, 16'h838F, 16'h8393, 16'h814A, 16'h814B
  };

  // Pending byte and what it is
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } hold_t;

  // Result group built for one input word (0..4 bytes)
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] data;
    logic            last;
  } res_t;

  // Queue entry: index of final byte instead of count (never empty)
  typedef struct packed {
    logic [1:0]      top;
    logic [3:0][7:0] data;
    logic            last;
  } entry_t;

  function automatic logic is_lead(logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  function automatic res_t push(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (o.cnt < 3'd4) begin
      o.data[o.cnt[1:0]] = b;
      o.cnt = o.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic res_t push_code(res_t r, logic [15:0] c);
    return push(push(r, c[15:8]), c[7:0]);
  endfunction

  // Held kana on its own: passed in half mode, otherwise widened
  function automatic res_t flush_kana(res_t r, logic [1:0] mode, logic [7:0] k);
    logic [7:0] off;
    res_t       o;
    off = k - KANA_LO;
    if (mode == MODE_HALF) begin
      o = push(r, k);
    end else if (mode == MODE_KATA) begin
      o = push_code(r, KATA_TAB[off[5:0]]);
    end else begin
      o = push_code(r, HIRA_TAB[off[5:0]]);
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/sjkw_ifs.sv =====
// sjkw_ifs: valid/ready channel interfaces for input and result words.
// Depends on nothing.
interface sjkw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sjkw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       out_last;

  modport source (output valid, output out_byte, output run_end, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input out_last,
                  output ready);
endinterface

// ===== rtl/core/sjis_kana_width_converter_unit.sv =====
// sjis_kana_width_converter_unit: top level of the Shift-JIS kana width converter.
// Depends on sjkw_pkg, sjkw_ifs (channel interfaces) and sjkw_step.
//
//  channel  | dir | payload                       | handshake
//  ---------+-----+-------------------------------+-------------------
//  in_ch    | in  | in_byte[7:0], in_last         | valid/ready
//  out_ch   | out | out_byte[7:0], run_end, out_last | valid/ready
//  cfg      | in  | cfg_data[1:0] (conversion mode) | cfg_we, no stall
//
// One input word is taken per cycle while the result queue has a free entry.
// Each word yields 0..4 result bytes (mostly 1 or 2), sent one per cycle while
// out_ch.ready is high; a word that only becomes pending yields no bytes and
// takes no queue entry. The first byte passes through queue write, memory read
// and the output register on its way out.
// Reset (rst_n low, synchronous) empties the queue, drops the pending byte
// and selects mode 0. out_ch.ready low stalls only the output side; input
// keeps flowing until all queue entries are taken.
module sjis_kana_width_converter_unit import sjkw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sjkw_in_if.sink       in_ch,
  sjkw_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_data
);

  // Configuration
  logic [1:0] mode_r;

  // Pending byte
  hold_t held_r;
  hold_t held_nxt;
  res_t  res;

  // Result queue: one entry per word that yields bytes
  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Registered read data and output register
  entry_t     rd_r;
  logic       rd_v_r;
  entry_t     cur_r;
  logic       cur_v_r;
  logic [1:0] pos_r;

  logic in_fire;
  logic wr;
  logic out_fire;
  logic cur_done;
  logic load_cur;
  logic rd_free;
  logic rd_issue;
  entry_t wr_entry;

  sjkw_step u_step (
    .mode_raw (mode_r),
    .held     (held_r),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .res      (res),
    .held_nxt (held_nxt)
  );

  assign in_ch.ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr          = in_fire && (res.cnt != 3'd0);

  assign wr_entry.top  = res.cnt[1:0] - 2'd1;  // count of 4 wraps to index 3
  assign wr_entry.data = res.data;
  assign wr_entry.last = res.last;

  // Output side: drain current group, refill from read register
  assign out_fire = cur_v_r && out_ch.ready;
  assign cur_done = out_fire && (pos_r == cur_r.top);
  assign load_cur = (!cur_v_r || cur_done) && rd_v_r;
  assign rd_free  = !rd_v_r || load_cur;
  assign rd_issue = rd_free && (cnt_r != '0);   // only committed entries, no overlap

  assign cnt_nxt = cnt_r + CNT_W'(wr) - CNT_W'(rd_issue);

  assign out_ch.valid    = cur_v_r;
  assign out_ch.out_byte = cur_r.data[pos_r];
  assign out_ch.run_end  = (pos_r == cur_r.top);
  assign out_ch.out_last = (pos_r == cur_r.top) && cur_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HALF;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (in_fire) begin
      held_r <= held_nxt;
    end
  end

  // Queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_entry;
    end
    if (rd_issue) begin
      rd_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (rd_issue) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
      if (rd_issue) begin
        rd_v_r <= 1'b1;
      end else if (load_cur) begin
        rd_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_r <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (load_cur) begin
        cur_v_r <= 1'b1;
        pos_r   <= '0;
      end else begin
        if (cur_done) begin
          cur_v_r <= 1'b0;
        end
        if (out_fire) begin
          pos_r <= pos_r + 2'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sjkw_step.sv =====
// sjkw_step: per-word conversion, builds the result group and next pending state.
// Depends on sjkw_pkg.
module sjkw_step import sjkw_pkg::*; (
  input  logic [1:0] mode_raw,
  input  hold_t      held,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output res_t       res,
  output hold_t      held_nxt
);

  logic [1:0]  mode;
  logic [15:0] code;
  logic        pair_hit;
  logic [7:0]  pair_base;
  logic [7:0]  pair_mark;
  logic        single_hit;
  logic [5:0]  single_idx;
  logic        kpair_hit;
  logic [15:0] kpair_kata;
  logic [15:0] kpair_hira;

  assign mode = (mode_raw == MODE_HIRA_ALT) ? MODE_HIRA : mode_raw;
  assign code = {held.data, in_byte};

  // Table searches, independent compares
  always_comb begin
    pair_hit   = 1'b0;
    pair_base  = '0;
    pair_mark  = '0;
    single_hit = 1'b0;
    single_idx = '0;
    kpair_hit  = 1'b0;
    kpair_kata = '0;
    kpair_hira = '0;
    for (int i = PAIR_N - 1; i >= 0; i--) begin
      if (PAIR_KATA[i] == code) begin
        pair_hit  = 1'b1;
        pair_base = PAIR_BASE[i];
        pair_mark = PAIR_MARK[i];
      end
      if (PAIR_BASE[i] == held.data && PAIR_MARK[i] == in_byte) begin
        kpair_hit  = 1'b1;
        kpair_kata = PAIR_KATA[i];
        kpair_hira = PAIR_HIRA[i];
      end
    end
    for (int i = SINGLE_N - 1; i >= 0; i--) begin
      if (KATA_TAB[i] == code) begin
        single_hit = 1'b1;
        single_idx = 6'(i);
      end
    end
  end

  always_comb begin
    res_t       r;
    hold_t      h;
    logic       consumed;
    r        = '0;
    h        = held;
    consumed = 1'b0;

    unique case (held.kind)
      KIND_LEAD: begin
        if (mode == MODE_HALF) begin
          if (pair_hit) begin
            r = push(push(r, pair_base), pair_mark);
          end else if (single_hit) begin
            r = push(r, (code == SJIS_IDEO_SPACE) ? ASCII_SPACE
                                                  : KANA_LO + {2'b00, single_idx});
          end else begin
            r = push(push(r, held.data), in_byte);
          end
        end else begin
          r = push(push(r, held.data), in_byte);
        end
        h.kind   = KIND_NONE;
        consumed = 1'b1;
      end
      KIND_KANA: begin
        if (mode != MODE_HALF && kpair_hit) begin
          r        = push_code(r, (mode == MODE_KATA) ? kpair_kata : kpair_hira);
          consumed = 1'b1;
        end else begin
          r = flush_kana(r, mode, held.data);
        end
        h.kind = KIND_NONE;
      end
      default: begin
      end
    endcase

    if (!consumed) begin
      if (is_lead(in_byte)) begin
        h.data = in_byte;
        h.kind = KIND_LEAD;
      end else if (mode != MODE_HALF && in_byte >= KANA_LO && in_byte <= KANA_HI) begin
        h.data = in_byte;
        h.kind = KIND_KANA;
      end else begin
        r = push(r, in_byte);
      end
    end

    // End of string: nothing may stay pending
    if (in_last) begin
      if (h.kind == KIND_LEAD) begin
        r = push(r, h.data);
      end else if (h.kind == KIND_KANA) begin
        r = flush_kana(r, mode, h.data);
      end
      h.kind = KIND_NONE;
      h.data = '0;
    end

    r.last   = in_last;
    res      = r;
    held_nxt = h;
  end

endmodule

// ===== rtl/core/sjkw_checker.sv =====
// sjkw_checker: port-level assertions for the kana width converter, bound to
// the top level. Depends on the top level's ports only.
module sjkw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       out_last
);

  // End of string always closes a word's run
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> run_end)
    else $error("out_last without run_end");

  // Reset empties the output register
  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // Reset leaves the queue empty, so input is open
  a_reset_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_end)
                                && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind sjis_kana_width_converter_unit sjkw_checker u_sjkw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_end   (out_ch.run_end),
  .out_last  (out_ch.out_last)
);

// ===== sim/sjis_kana_width_converter_unit_test.sv =====
// Self-checking bench for sjis_kana_width_converter_unit: directed and random
// Shift-JIS text in every mode, checked word by word against a local model.
// Depends on sjkw_pkg and the sjkw_in_if / sjkw_out_if channel interfaces.
`timescale 1ns / 1ps

module sjis_kana_width_converter_unit_test;
  import sjkw_pkg::*;

  localparam int IDLE_PCT      = 37;    // chance of a gap / stall per decision
  localparam int SETTLE_CYCLES = 10;    // margin past the queue write, memory read and output register
  localparam int HOLD_CYCLES   = 80;    // long output hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int RANDOM_WORDS  = 150;
  localparam int REPORT_MAX    = 10;

  // Shift-JIS byte classes
  localparam logic [7:0]  LEAD1_LO   = 8'h81;
  localparam logic [7:0]  LEAD1_HI   = 8'h9F;
  localparam logic [7:0]  LEAD2_LO   = 8'hE0;
  localparam logic [7:0]  LEAD2_HI   = 8'hFC;
  localparam logic [7:0]  HALF_LO    = 8'hA0;
  localparam logic [7:0]  HALF_HI    = 8'hDF;
  localparam logic [7:0]  VOICED     = 8'hDE;   // dakuten
  localparam logic [7:0]  SEMIVOICED = 8'hDF;   // handakuten
  localparam logic [15:0] WIDE_SPACE = 16'h8140;
  localparam logic [7:0]  NARROW_SPC = 8'h20;

  // Voiced pairs: the first 21 take the dakuten, the last five the handakuten
  localparam int VOICED_N = 26;
  localparam int DAKU_N   = 21;
  localparam logic [7:0] PAIR_KANA [VOICED_N] = '{
    8'hB3, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
    8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hCA, 8'hCB, 8'hCC, 8'hCD,
    8'hCE, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE
  };
  localparam logic [15:0] PAIR_HIRAGANA [VOICED_N] = '{
    16'h8394, 16'h82AA, 16'h82AC, 16'h82AE, 16'h82B0, 16'h82B2, 16'h82B4,
    16'h82B6, 16'h82B8, 16'h82BA, 16'h82BC, 16'h82BE, 16'h82C0, 16'h82C3,
    16'h82C5, 16'h82C7, 16'h82CE, 16'h82D1, 16'h82D4, 16'h82D7, 16'h82DA,
    16'h82CF, 16'h82D2, 16'h82D5, 16'h82D8, 16'h82DB
  };
  localparam logic [15:0] PAIR_KATAKANA [VOICED_N] = '{
    16'h8394, 16'h834B, 16'h834D, 16'h834F, 16'h8351, 16'h8353, 16'h8355,
    16'h8357, 16'h8359, 16'h835B, 16'h835D, 16'h835F, 16'h8361, 16'h8364,
    16'h8366, 16'h8368, 16'h836F, 16'h8372, 16'h8375, 16'h8378, 16'h837B,
    16'h8370, 16'h8373, 16'h8376, 16'h8379, 16'h837C
  };

  // Full-width forms of the half-width codes, indexed by code minus 0xA0
  localparam logic [15:0] WIDE_HIRAGANA [64] = '{
    16'h8140, 16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h82F0, 16'h829F,
    16'h82A1, 16'h82A3, 16'h82A5, 16'h82A7, 16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1,
    16'h815B, 16'h82A0, 16'h82A2, 16'h82A4, 16'h82A6, 16'h82A8, 16'h82A9, 16'h82AB,
    16'h82AD, 16'h82AF, 16'h82B1, 16'h82B3, 16'h82B5, 16'h82B7, 16'h82B9, 16'h82BB,
    16'h82BD, 16'h82BF, 16'h82C2, 16'h82C4, 16'h82C6, 16'h82C8, 16'h82C9, 16'h82CA,
    16'h82CB, 16'h82CC, 16'h82CD, 16'h82D0, 16'h82D3, 16'h82D6, 16'h82D9, 16'h82DC,
    16'h82DD, 16'h82DE, 16'h82DF, 16'h82E0, 16'h82E2, 16'h82E4, 16'h82E6, 16'h82E7,
    16'h82E8, 16'h82E9, 16'h82EA, 16'h82EB, 16'h82ED, 16'h82F1, 16'h814A, 16'h814B
  };
  localparam logic [15:0] WIDE_KATAKANA [64] = '{
    16'h8140, 16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340,
    16'h8342, 16'h8344, 16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362,
    16'h815B, 16'h8341, 16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834A, 16'h834C,
    16'h834E, 16'h8350, 16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835A, 16'h835C,
    16'h835E, 16'h8360, 16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836A, 16'h836B,
    16'h836C, 16'h836D, 16'h836E, 16'h8371, 16'h8374, 16'h8377, 16'h837A, 16'h837D,
    16'h837E, 16'h8380, 16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389,
    16'h838A, 16'h838B, 16'h838C, 16'h838D, 16'h838F, 16'h8393, 16'h814A, 16'h814B
  };

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       ends_text;
  } out_word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_data;

  sjkw_in_if  in_ch ();
  sjkw_out_if out_ch ();

  sjis_kana_width_converter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Local copy of the converter state
  logic [1:0] mode_reg;
  logic [7:0] pend_byte;
  logic [1:0] pend_kind;

  out_word_t  converted_q [$];   // bytes still owed by the block, oldest first
  logic [7:0] word_bytes [$];    // scratch: bytes produced by one input word
  logic [7:0] text_q [$];        // string being sent

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int words_sent, strings_sent, bytes_checked, mode_writes;
  int mismatches, strays;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Width conversion model
  // -------------------------------------------------------------------------
  function automatic bit is_sjis_lead(logic [7:0] b);
    return (b >= LEAD1_LO && b <= LEAD1_HI) || (b >= LEAD2_LO && b <= LEAD2_HI);
  endfunction

  function automatic void push_code(logic [15:0] c);
    word_bytes.push_back(c[15:8]);
    word_bytes.push_back(c[7:0]);
  endfunction

  // Lone half-width kana: unchanged in narrowing mode, else widened
  function automatic void widen_kana(logic [1:0] m, logic [7:0] k);
    logic [7:0] off;
    off = k - HALF_LO;
    if (m == MODE_HALF)
      word_bytes.push_back(k);
    else if (m == MODE_KATA)
      push_code(WIDE_KATAKANA[off[5:0]]);
    else
      push_code(WIDE_HIRAGANA[off[5:0]]);
  endfunction

  // One accepted word: update local state and queue the bytes it owes
  function automatic void convert_word(logic [7:0] b, logic fin);
    logic [1:0]  m;
    logic [15:0] code;
    bit          taken;
    bit          found;
    out_word_t   w;
    m     = (mode_reg == MODE_HIRA_ALT) ? MODE_HIRA : mode_reg;
    taken = 1'b0;
    found = 1'b0;
    word_bytes.delete();

    if (pend_kind == KIND_LEAD) begin
      // any byte after a lead is its trail
      if (m == MODE_HALF) begin
        code = {pend_byte, b};
        for (int i = 0; i < VOICED_N && !found; i++)
          if (PAIR_KATAKANA[i] == code) begin
            word_bytes.push_back(PAIR_KANA[i]);
            word_bytes.push_back(i < DAKU_N ? VOICED : SEMIVOICED);
            found = 1'b1;
          end
        for (int i = 0; i < 64 && !found; i++)
          if (WIDE_KATAKANA[i] == code) begin
            word_bytes.push_back(code == WIDE_SPACE ? NARROW_SPC : 8'(HALF_LO + i));
            found = 1'b1;
          end
        if (!found) begin
          word_bytes.push_back(pend_byte);
          word_bytes.push_back(b);
        end
      end else begin
        word_bytes.push_back(pend_byte);
        word_bytes.push_back(b);
      end
      pend_kind = KIND_NONE;
      taken     = 1'b1;
    end else if (pend_kind == KIND_KANA) begin
      // a held kana may join a following mark, unless we are now narrowing
      if (m != MODE_HALF)
        for (int i = 0; i < VOICED_N && !taken; i++)
          if (PAIR_KANA[i] == pend_byte && (i < DAKU_N ? VOICED : SEMIVOICED) == b) begin
            push_code(m == MODE_KATA ? PAIR_KATAKANA[i] : PAIR_HIRAGANA[i]);
            taken = 1'b1;
          end
      if (!taken)
        widen_kana(m, pend_byte);
      pend_kind = KIND_NONE;
    end

    if (!taken) begin
      if (is_sjis_lead(b)) begin
        pend_byte = b;
        pend_kind = KIND_LEAD;
      end else if (m != MODE_HALF && b >= HALF_LO && b <= HALF_HI) begin
        pend_byte = b;
        pend_kind = KIND_KANA;
      end else begin
        word_bytes.push_back(b);
      end
    end

    // end of string flushes whatever is held
    if (fin) begin
      if (pend_kind == KIND_LEAD)
        word_bytes.push_back(pend_byte);
      else if (pend_kind == KIND_KANA)
        widen_kana(m, pend_byte);
      pend_kind = KIND_NONE;
      pend_byte = '0;
    end

    while (word_bytes.size() > 4)
      word_bytes.pop_back();
    foreach (word_bytes[i]) begin
      w.data      = word_bytes[i];
      w.run_end   = (i == word_bytes.size() - 1);
      w.ends_text = w.run_end && fin;
      converted_q.push_back(w);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Input side: one word per call, entered and left at a falling edge
  // -------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic fin);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    convert_word(b, fin);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i])
      send_word(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  // Drop valid, let every owed byte arrive, then allow for the pipe latency
  // in case the last word only became pending.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (converted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called with the block idle
  task automatic write_mode(input logic [1:0] m);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    mode_reg  = m;
    mode_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_text_code(logic [15:0] c);
    text_q.push_back(c[15:8]);
    text_q.push_back(c[7:0]);
  endfunction

  // Random string for a mode: mostly well-formed kana text, some noise
  function automatic void build_text(logic [1:0] m);
    int         chars;
    int         r;
    logic [7:0] lead;
    text_q.delete();
    chars = $urandom_range(1, 10);
    repeat (chars) begin
      r    = $urandom_range(99);
      lead = $urandom_range(1) ? 8'($urandom_range(LEAD1_LO, LEAD1_HI))
                               : 8'($urandom_range(LEAD2_LO, LEAD2_HI));
      if (m == MODE_HALF) begin
        if (r < 40)
          push_text_code(WIDE_KATAKANA[$urandom_range(63)]);
        else if (r < 60)
          push_text_code(PAIR_KATAKANA[$urandom_range(VOICED_N - 1)]);
        else if (r < 70)
          push_text_code(WIDE_HIRAGANA[$urandom_range(63)]);
        else if (r < 80)
          push_text_code({lead, 8'($urandom_range(255))});
        else if (r < 95)
          text_q.push_back(8'($urandom_range(255)));
        else
          text_q.push_back(8'($urandom_range(HALF_LO, HALF_HI)));
      end else begin
        if (r < 45) begin
          text_q.push_back(8'($urandom_range(HALF_LO, HALF_HI)));
        end else if (r < 70) begin
          r = $urandom_range(VOICED_N - 1);
          text_q.push_back(PAIR_KANA[r]);
          text_q.push_back(r < DAKU_N ? VOICED : SEMIVOICED);
        end else if (r < 78) begin
          // kana followed by a mark it may not take
          text_q.push_back(8'($urandom_range(HALF_LO, HALF_HI)));
          text_q.push_back($urandom_range(1) ? VOICED : SEMIVOICED);
        end else if (r < 88) begin
          push_text_code({lead, 8'($urandom_range(255))});
        end else begin
          text_q.push_back(8'($urandom_range(255)));
        end
      end
    end
    // broken ending: a stray lead byte closes the string
    if ($urandom_range(9) == 0)
      text_q.push_back(LEAD2_HI);
  endfunction

  // -------------------------------------------------------------------------
  // Output side: ready driver with random stalls and a requested hold-off
  // -------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Every result word is compared with the oldest owed byte
  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (converted_q.size() == 0) begin
        strays++;
        if (mismatches + strays <= REPORT_MAX)
          $display("%0t: unexpected word byte %h run_end %b last %b", $time,
                   out_ch.out_byte, out_ch.run_end, out_ch.out_last);
      end else begin
        w = converted_q.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== w.data || out_ch.run_end !== w.run_end ||
            out_ch.out_last !== w.ends_text) begin
          mismatches++;
          if (mismatches + strays <= REPORT_MAX)
            $display("%0t: mismatch, expected byte %h run_end %b last %b, got %h %b %b",
                     $time, w.data, w.run_end, w.ends_text,
                     out_ch.out_byte, out_ch.run_end, out_ch.out_last);
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("sjis_kana_width_converter_unit regression: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Narrowing straight out of reset (mode 0 is the reset value)
  task automatic test_narrowing();
    send_word(8'h83, 1'b0); send_word(8'h94, 1'b0);   // voiced pair -> B3 DE
    send_word(8'h83, 1'b0); send_word(8'h40, 1'b0);   // single kana
    send_word(8'h81, 1'b0); send_word(8'h40, 1'b0);   // ideographic space
    send_word(8'h88, 1'b0); send_word(8'h9F, 1'b0);   // kanji, unchanged
    send_word(HALF_LO, 1'b0);                          // half kana passes
    send_word(8'hFF, 1'b0);
    send_word(LEAD2_HI, 1'b0); send_word(8'h00, 1'b0); // zero as a trail
    send_word(LEAD2_LO, 1'b1);                         // lead at end of string
    settle();
  endtask

  task automatic test_widening();
    write_mode(MODE_KATA);
    send_word(8'hB6, 1'b0); send_word(VOICED, 1'b0);  // joined pair
    send_word(8'hB1, 1'b0); send_word(VOICED, 1'b0);  // no such pair: both alone
    send_word(8'h41, 1'b0);
    send_word(SEMIVOICED, 1'b1);                       // kana at end of string
    settle();
    write_mode(MODE_HIRA);
    send_word(8'hCA, 1'b0); send_word(SEMIVOICED, 1'b1);
    settle();
    // code 3 must behave as hiragana
    write_mode(MODE_HIRA_ALT);
    send_word(8'hB6, 1'b0); send_word(VOICED, 1'b0);
    send_word(8'hB1, 1'b1);
    settle();
  endtask

  // Mode changed while a byte is held: the next byte sees the new mode
  task automatic test_mode_switch_held();
    write_mode(MODE_KATA);
    send_word(8'hB6, 1'b0);
    settle();
    write_mode(MODE_HALF);
    send_word(VOICED, 1'b1);      // held kana now passed unchanged
    settle();
    send_word(8'h83, 1'b0);
    settle();
    write_mode(MODE_KATA);
    send_word(8'h94, 1'b1);       // held lead passes with its trail
    settle();
  endtask

  // Output held off while the input keeps offering: queue fills, input stalls
  task automatic test_backpressure();
    int start;
    start = words_sent;
    write_mode(MODE_KATA);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    while (words_sent - start < 30) begin
      build_text(MODE_KATA);
      send_text();
    end
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_text();
    int         start;
    int         phase;
    int         n;
    logic [1:0] m;
    start = words_sent;
    phase = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      // walk every mode first, then pick at random
      m = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
      write_mode(m);
      idle_on = (phase != 2);     // one long stretch with no idling
      n = (phase == 2) ? 6 : $urandom_range(1, 3);
      repeat (n) begin
        build_text(m);
        send_text();
      end
      settle();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= MODE_HALF;
    rst_n         <= 1'b0;
    mode_reg  = MODE_HALF;
    pend_byte = '0;
    pend_kind = KIND_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_narrowing();
    test_widening();
    test_mode_switch_held();
    test_backpressure();
    test_random_text();

    // settle() has already drained; anything left is owed and missing
    if (converted_q.size() != 0)
      $display("%0d result words never arrived", converted_q.size());

    $display("covered %0d words in %0d strings, all four mode codes (%0d writes),",
             words_sent, strings_sent, mode_writes);
    $display("held bytes across mode changes and a %0d-cycle output hold; %0d bytes checked",
             HOLD_CYCLES, bytes_checked);
    if (mismatches == 0 && strays == 0 && converted_q.size() == 0)
      $display("sjis_kana_width_converter_unit regression: pass");
    else
      $display("sjis_kana_width_converter_unit regression: fail");
    $finish;
  end

endmodule
